FILE: sv/lmrs_pkg.sv
// ----------------------------------------------------------------------------
// lmrs_pkg
// Shared types and constants for the LED matrix row-scan driver.
// ----------------------------------------------------------------------------
`default_nettype none

package lmrs_pkg;

    localparam int SECTIONS_ACROSS_DEF = 4;
    localparam int SECTION_BANDS_DEF   = 2;
    localparam int SECTION_HEIGHT_DEF  = 8;

    localparam int SECTION_WIDTH = 8;
    localparam int COLOR_W       = 6;
    localparam int COLORS        = 3;
    localparam int LEVELS        = 4;
    localparam int LVL_W         = COLORS * LEVELS * SECTION_WIDTH;

    typedef enum logic [1:0] {
        FUNC_WRITE = 2'b00,
        FUNC_SWAP  = 2'b01,
        FUNC_TICK  = 2'b10
    } func_t;

endpackage

`default_nettype wire

FILE: sv/lmrs_ram.sv
// ----------------------------------------------------------------------------
// lmrs_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module lmrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[waddr] <= wdata;
        end
        if (rd_en) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: sv/lmrs_gather.sv
// ----------------------------------------------------------------------------
// lmrs_gather
// Reads one row of every section from the front buffer and builds the
// per-section level masks, one level-memory word per section.
// ----------------------------------------------------------------------------
`default_nettype none

module lmrs_gather #(
    parameter int SECTIONS_ACROSS = lmrs_pkg::SECTIONS_ACROSS_DEF,
    parameter int SECTION_BANDS   = lmrs_pkg::SECTION_BANDS_DEF,
    parameter int SECTION_HEIGHT  = lmrs_pkg::SECTION_HEIGHT_DEF,
    parameter int SC     = SECTIONS_ACROSS * SECTION_BANDS,
    parameter int SEC_W  = (SC > 1) ? $clog2(SC) : 1,
    parameter int ROW_W  = $clog2(SECTION_HEIGHT),
    parameter int XW     = $clog2(SECTIONS_ACROSS * lmrs_pkg::SECTION_WIDTH),
    parameter int YW     = $clog2(SECTION_BANDS * SECTION_HEIGHT),
    parameter int FA_W   = 1 + YW + XW
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         start,
    input  wire logic                         front_buf,
    input  wire logic [ROW_W-1:0]             row,
    output logic                              frame_rd_en,
    output logic      [FA_W-1:0]              frame_raddr,
    input  wire logic [lmrs_pkg::COLOR_W-1:0] frame_rdata,
    output logic                              lvl_wr_en,
    output logic      [SEC_W-1:0]             lvl_waddr,
    output logic      [lmrs_pkg::LVL_W-1:0]   lvl_wdata,
    output logic                              done
);
    import lmrs_pkg::*;

    localparam int COL_W  = (SECTIONS_ACROSS > 1) ? $clog2(SECTIONS_ACROSS) : 1;
    localparam int BAND_W = (SECTION_BANDS > 1) ? $clog2(SECTION_BANDS) : 1;

    logic              active_reg, active_next;
    logic [2:0]        off_reg, off_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [BAND_W-1:0] band_reg, band_next;
    logic [SEC_W-1:0]  sec_reg, sec_next;
    logic [YW-1:0]     ybase_reg, ybase_next;
    logic              buf_reg, buf_next;
    logic [ROW_W-1:0]  row_reg, row_next;

    logic              pv_reg;
    logic [2:0]        poff_reg;
    logic [SEC_W-1:0]  psec_reg;
    logic [LVL_W-1:0]  acc_reg, acc_next;

    logic [31:0]       mcol, xoff, x32, y32;
    logic              mirrored, last_issue;
    logic [7:0]        bit_mask;
    logic [1:0]        comp;

    always_comb begin
        mirrored = band_reg[0];
        mcol     = mirrored ? 32'(SECTIONS_ACROSS - 1) - 32'(col_reg) : 32'(col_reg);
        xoff     = mirrored ? 32'(7) - 32'(off_reg) : 32'(off_reg);
        x32      = mcol * 32'(SECTION_WIDTH) + xoff;
        y32      = 32'(ybase_reg) + 32'(row_reg);
        frame_rd_en = active_reg;
        frame_raddr = {buf_reg, y32[YW-1:0], x32[XW-1:0]};
        last_issue  = (sec_reg == SEC_W'(SC - 1)) && (off_reg == 3'd7);
    end

    always_comb begin
        active_next = active_reg;
        off_next    = off_reg;
        col_next    = col_reg;
        band_next   = band_reg;
        sec_next    = sec_reg;
        ybase_next  = ybase_reg;
        buf_next    = buf_reg;
        row_next    = row_reg;
        if (!active_reg && start) begin
            active_next = 1'b1;
            off_next    = '0;
            col_next    = '0;
            band_next   = '0;
            sec_next    = '0;
            ybase_next  = '0;
            buf_next    = front_buf;
            row_next    = row;
        end else if (active_reg) begin
            off_next = off_reg + 3'd1;
            if (off_reg == 3'd7) begin
                sec_next = sec_reg + SEC_W'(1);
                if (col_reg == COL_W'(SECTIONS_ACROSS - 1)) begin
                    col_next   = '0;
                    band_next  = band_reg + BAND_W'(1);
                    ybase_next = ybase_reg + YW'(SECTION_HEIGHT);
                end else begin
                    col_next = col_reg + COL_W'(1);
                end
            end
            if (last_issue) begin
                active_next = 1'b0;
            end
        end
    end

    always_comb begin
        bit_mask = 8'd1 << poff_reg;
        acc_next = (poff_reg == 3'd0) ? '0 : acc_reg;
        for (int c = 0; c < COLORS; c++) begin
            comp = frame_rdata[2*c +: 2];
            if (comp != 2'd0) begin
                acc_next[(c*LEVELS + 0)*8 +: 8] = acc_next[(c*LEVELS + 0)*8 +: 8] | bit_mask;
                acc_next[(c*LEVELS + 1)*8 +: 8] = acc_next[(c*LEVELS + 1)*8 +: 8] | bit_mask;
            end
            if (comp[1]) begin
                acc_next[(c*LEVELS + 2)*8 +: 8] = acc_next[(c*LEVELS + 2)*8 +: 8] | bit_mask;
            end
            if (comp == 2'd3) begin
                acc_next[(c*LEVELS + 3)*8 +: 8] = acc_next[(c*LEVELS + 3)*8 +: 8] | bit_mask;
            end
        end
        lvl_wr_en = pv_reg && (poff_reg == 3'd7);
        lvl_waddr = psec_reg;
        lvl_wdata = acc_next;
        done      = lvl_wr_en && (psec_reg == SEC_W'(SC - 1));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            pv_reg     <= 1'b0;
        end else begin
            active_reg <= active_next;
            pv_reg     <= active_reg;
        end
        off_reg   <= off_next;
        col_reg   <= col_next;
        band_reg  <= band_next;
        sec_reg   <= sec_next;
        ybase_reg <= ybase_next;
        buf_reg   <= buf_next;
        row_reg   <= row_next;
        poff_reg  <= off_reg;
        psec_reg  <= sec_reg;
        if (pv_reg) begin
            acc_reg <= acc_next;
        end
    end

endmodule

`default_nettype wire

FILE: sv/lmrs_emit.sv
// ----------------------------------------------------------------------------
// lmrs_emit
// Reads the level word of each section and sends its red, green and blue
// bytes for the current bit-plane step through a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module lmrs_emit #(
    parameter int SECTIONS_ACROSS = lmrs_pkg::SECTIONS_ACROSS_DEF,
    parameter int SECTION_BANDS   = lmrs_pkg::SECTION_BANDS_DEF,
    parameter int SECTION_HEIGHT  = lmrs_pkg::SECTION_HEIGHT_DEF,
    parameter int SC    = SECTIONS_ACROSS * SECTION_BANDS,
    parameter int SEC_W = (SC > 1) ? $clog2(SC) : 1,
    parameter int ROW_W = $clog2(SECTION_HEIGHT)
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       start,
    input  wire logic [1:0]                 step,
    input  wire logic [ROW_W-1:0]           row,
    output logic                            lvl_rd_en,
    output logic      [SEC_W-1:0]           lvl_raddr,
    input  wire logic [lmrs_pkg::LVL_W-1:0] lvl_rdata,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic      [7:0]                 m_data_byte,
    output logic                            m_last_byte,
    output logic      [7:0]                 m_row_select_n,
    output logic                            done
);
    import lmrs_pkg::*;

    typedef enum logic [2:0] {
        E_IDLE = 3'b001,
        E_READ = 3'b010,
        E_SEND = 3'b100
    } emit_state_t;

    emit_state_t      state_reg, state_next;
    logic [SEC_W-1:0] sec_reg, sec_next;
    logic [1:0]       col_reg, col_next;
    logic [1:0]       step_reg, step_next;
    logic [ROW_W-1:0] row_reg, row_next;

    logic             m_valid_reg, m_valid_next;
    logic [7:0]       data_reg, data_next;
    logic             last_reg, last_next;
    logic [7:0]       sel_reg, sel_next;

    logic             load, last_sec, last_col;
    logic [6:0]       base;
    logic [31:0]      r32;
    logic [7:0]       row_sel;

    always_comb begin
        r32      = 32'(row_reg);
        row_sel  = (r32 < 32'd8) ? ~(8'd1 << r32[2:0]) : 8'hFF;
        base     = {col_reg, step_reg, 3'b000};
        last_sec = (sec_reg == SEC_W'(SC - 1));
        last_col = (col_reg == 2'd2);
        load     = (state_reg == E_SEND) && (!m_valid_reg || m_ready);
    end

    always_comb begin
        state_next   = state_reg;
        sec_next     = sec_reg;
        col_next     = col_reg;
        step_next    = step_reg;
        row_next     = row_reg;
        lvl_rd_en    = 1'b0;
        lvl_raddr    = sec_reg;
        done         = 1'b0;
        m_valid_next = m_valid_reg;
        data_next    = data_reg;
        last_next    = last_reg;
        sel_next     = sel_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            E_IDLE: begin
                if (start) begin
                    sec_next   = '0;
                    step_next  = step;
                    row_next   = row;
                    state_next = E_READ;
                end
            end
            E_READ: begin
                lvl_rd_en  = 1'b1;
                col_next   = 2'd0;
                state_next = E_SEND;
            end
            E_SEND: begin
                if (load) begin
                    m_valid_next = 1'b1;
                    data_next    = lvl_rdata[base +: 8];
                    last_next    = last_sec && last_col;
                    sel_next     = (last_sec && last_col) ? row_sel : 8'hFF;
                    if (last_col) begin
                        if (last_sec) begin
                            done       = 1'b1;
                            state_next = E_IDLE;
                        end else begin
                            sec_next   = sec_reg + SEC_W'(1);
                            state_next = E_READ;
                        end
                    end else begin
                        col_next = col_reg + 2'd1;
                    end
                end
            end
            default: state_next = E_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= E_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        sec_reg  <= sec_next;
        col_reg  <= col_next;
        step_reg <= step_next;
        row_reg  <= row_next;
        data_reg <= data_next;
        last_reg <= last_next;
        sel_reg  <= sel_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_data_byte    = data_reg;
    assign m_last_byte    = last_reg;
    assign m_row_select_n = sel_reg;

endmodule

`default_nettype wire

FILE: sv/led_matrix_row_scan_driver_top.sv
// ----------------------------------------------------------------------------
// led_matrix_row_scan_driver_top
// Double-buffered RGB LED matrix row-scan driver with bit-plane output.
// ----------------------------------------------------------------------------
// Pixel writes and swaps can be accepted back to back while no scan tick is busy.
// A scan tick at step 0 first gathers the row: 8 frame RAM reads per section,
// one per cycle, then every tick sends 3 bytes per section with one level RAM
// read per section. The default frame is 32x16 pixels.
// Synchronous active-low reset clears control state; frame RAM is not cleared.
`default_nettype none

module led_matrix_row_scan_driver_top #(
    parameter int SECTIONS_ACROSS = lmrs_pkg::SECTIONS_ACROSS_DEF,
    parameter int SECTION_BANDS   = lmrs_pkg::SECTION_BANDS_DEF,
    parameter int SECTION_HEIGHT  = lmrs_pkg::SECTION_HEIGHT_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [1:0] s_func,
    input  wire logic [4:0] s_pixel_x,
    input  wire logic [3:0] s_pixel_y,
    input  wire logic [5:0] s_pixel_color,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic      [7:0] m_data_byte,
    output logic            m_last_byte,
    output logic      [7:0] m_row_select_n
);
    import lmrs_pkg::*;

    localparam int FRAME_W = SECTIONS_ACROSS * SECTION_WIDTH;
    localparam int FRAME_H = SECTION_BANDS * SECTION_HEIGHT;
    localparam int SC      = SECTIONS_ACROSS * SECTION_BANDS;
    localparam int SEC_W   = (SC > 1) ? $clog2(SC) : 1;
    localparam int ROW_W   = $clog2(SECTION_HEIGHT);
    localparam int XW      = $clog2(FRAME_W);
    localparam int YW      = $clog2(FRAME_H);
    localparam int FA_W    = 1 + YW + XW;

    logic             busy_reg, busy_next;
    logic             front_reg, front_next;
    logic             swap_pending_reg, swap_pending_next;
    logic             frame_reading_reg, frame_reading_next;
    logic [1:0]       step_reg, step_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [1:0]       cur_step_reg, cur_step_next;
    logic [ROW_W-1:0] cur_row_reg, cur_row_next;
    logic             gbuf_reg, gbuf_next;
    logic             gstart_reg, gstart_next;
    logic             estart_reg, estart_next;

    logic             accept;
    logic [31:0]      px32, py32;
    logic             fr_wr_en;
    logic [FA_W-1:0]  fr_waddr;
    logic             fr_rd_en;
    logic [FA_W-1:0]  fr_raddr;
    logic [COLOR_W-1:0] fr_rdata;
    logic             lv_wr_en;
    logic [SEC_W-1:0] lv_waddr;
    logic [LVL_W-1:0] lv_wdata;
    logic             lv_rd_en;
    logic [SEC_W-1:0] lv_raddr;
    logic [LVL_W-1:0] lv_rdata;
    logic             gather_done, emit_done;

    assign s_ready = !busy_reg;
    assign accept  = s_valid && s_ready;

    always_comb begin
        px32     = 32'(s_pixel_x);
        py32     = 32'(s_pixel_y);
        fr_wr_en = accept && (s_func == FUNC_WRITE)
                   && (px32 < 32'(FRAME_W)) && (py32 < 32'(FRAME_H));
        fr_waddr = {~front_reg, py32[YW-1:0], px32[XW-1:0]};
    end

    always_comb begin
        busy_next          = busy_reg;
        front_next         = front_reg;
        swap_pending_next  = swap_pending_reg;
        frame_reading_next = frame_reading_reg;
        step_next          = step_reg;
        row_next           = row_reg;
        cur_step_next      = cur_step_reg;
        cur_row_next       = cur_row_reg;
        gbuf_next          = gbuf_reg;
        gstart_next        = 1'b0;
        estart_next        = 1'b0;
        if (emit_done) begin
            busy_next = 1'b0;
        end
        if (accept && (s_func == FUNC_SWAP)) begin
            if (frame_reading_reg) begin
                swap_pending_next = 1'b1;
            end else begin
                front_next = ~front_reg;
            end
        end
        if (accept && (s_func == FUNC_TICK)) begin
            busy_next     = 1'b1;
            cur_step_next = step_reg;
            cur_row_next  = row_reg;
            gbuf_next     = front_reg;
            if (step_reg == 2'd0) begin
                gstart_next = 1'b1;
                if (row_reg == '0) begin
                    frame_reading_next = 1'b1;
                end
                if (row_reg == ROW_W'(SECTION_HEIGHT - 1)) begin
                    frame_reading_next = 1'b0;
                    if (swap_pending_reg) begin
                        swap_pending_next = 1'b0;
                        front_next        = ~front_reg;
                    end
                end
            end else begin
                estart_next = 1'b1;
            end
            step_next = step_reg + 2'd1;
            if (step_reg == 2'd3) begin
                row_next = (row_reg == ROW_W'(SECTION_HEIGHT - 1)) ? '0
                                                                    : row_reg + ROW_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg          <= 1'b0;
            front_reg         <= 1'b0;
            swap_pending_reg  <= 1'b0;
            frame_reading_reg <= 1'b0;
            step_reg          <= 2'd0;
            row_reg           <= '0;
            gstart_reg        <= 1'b0;
            estart_reg        <= 1'b0;
        end else begin
            busy_reg          <= busy_next;
            front_reg         <= front_next;
            swap_pending_reg  <= swap_pending_next;
            frame_reading_reg <= frame_reading_next;
            step_reg          <= step_next;
            row_reg           <= row_next;
            gstart_reg        <= gstart_next;
            estart_reg        <= estart_next;
        end
        cur_step_reg <= cur_step_next;
        cur_row_reg  <= cur_row_next;
        gbuf_reg     <= gbuf_next;
    end

    lmrs_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (2 ** FA_W)
    ) u_frame_ram (
        .aclk  (aclk),
        .wr_en (fr_wr_en),
        .waddr (fr_waddr),
        .wdata (s_pixel_color),
        .rd_en (fr_rd_en),
        .raddr (fr_raddr),
        .rdata (fr_rdata)
    );

    lmrs_ram #(
        .WIDTH (LVL_W),
        .DEPTH (SC)
    ) u_level_ram (
        .aclk  (aclk),
        .wr_en (lv_wr_en),
        .waddr (lv_waddr),
        .wdata (lv_wdata),
        .rd_en (lv_rd_en),
        .raddr (lv_raddr),
        .rdata (lv_rdata)
    );

    lmrs_gather #(
        .SECTIONS_ACROSS (SECTIONS_ACROSS),
        .SECTION_BANDS   (SECTION_BANDS),
        .SECTION_HEIGHT  (SECTION_HEIGHT)
    ) u_gather (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start       (gstart_reg),
        .front_buf   (gbuf_reg),
        .row         (cur_row_reg),
        .frame_rd_en (fr_rd_en),
        .frame_raddr (fr_raddr),
        .frame_rdata (fr_rdata),
        .lvl_wr_en   (lv_wr_en),
        .lvl_waddr   (lv_waddr),
        .lvl_wdata   (lv_wdata),
        .done        (gather_done)
    );

    lmrs_emit #(
        .SECTIONS_ACROSS (SECTIONS_ACROSS),
        .SECTION_BANDS   (SECTION_BANDS),
        .SECTION_HEIGHT  (SECTION_HEIGHT)
    ) u_emit (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .start          (estart_reg || gather_done),
        .step           (cur_step_reg),
        .row            (cur_row_reg),
        .lvl_rd_en      (lv_rd_en),
        .lvl_raddr      (lv_raddr),
        .lvl_rdata      (lv_rdata),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data_byte    (m_data_byte),
        .m_last_byte    (m_last_byte),
        .m_row_select_n (m_row_select_n),
        .done           (emit_done)
    );

endmodule

`default_nettype wire
